// ===== hdl/bpc_pkg.sv =====
// Package: shared types for the button press classifier.
`default_nettype none
package bpc_pkg;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned OutCntWidth  = 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE_TICKS   = 2'd0,
    CFG_LONG_PRESS_TICKS = 2'd1,
    CFG_IDLE_LEVEL       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_HELD     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef struct packed {
    logic [CfgDataWidth-1:0] debounce_ticks;
    logic [CfgDataWidth-1:0] long_press_ticks;
    logic                    idle_level;
  } bpc_cfg_t;

  typedef struct packed {
    event_e                 press_event;
    logic [OutCntWidth-1:0] short_count;
    logic [OutCntWidth-1:0] long_count;
    phase_e                 button_state;
  } bpc_result_t;

endpackage
`default_nettype wire

// ===== hdl/bpc_in_if.sv =====
// Interface: input tick channel (pin sample and read-and-clear flag).
`default_nettype none
interface bpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic read_and_clear;

  modport source (output valid, output pin_level, output read_and_clear, input ready);
  modport sink   (input valid, input pin_level, input read_and_clear, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_out_if.sv =====
// Interface: result channel (event, counts and button state).
`default_nettype none
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  logic [7:0] short_count;
  logic [7:0] long_count;
  logic [1:0] button_state;

  modport source (output valid, output press_event, output short_count,
                  output long_count, output button_state, input ready);
  modport sink   (input valid, input press_event, input short_count,
                  input long_count, input button_state, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_fsm.sv =====
// Debounce and short/long press state machine with saturating counters.
`default_nettype none
module bpc_fsm #(
  parameter int unsigned COUNT_WIDTH = 8,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       pin_level_i,
  input  wire                       read_clear_i,
  input  wire bpc_pkg::bpc_cfg_t    cfg_i,
  output bpc_pkg::bpc_result_t      result_o
);
  import bpc_pkg::*;

  localparam int unsigned CmpWidth =
    (TIMER_WIDTH > CfgDataWidth) ? TIMER_WIDTH : CfgDataWidth;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  phase_e                 phase_q, phase_d;
  event_e                 event_q, event_d, event_upd;
  logic [TIMER_WIDTH-1:0] tick_q, tick_d, tick_inc;
  logic                   prev_q;
  logic [COUNT_WIDTH-1:0] short_q, short_d, short_upd;
  logic [COUNT_WIDTH-1:0] long_q, long_d, long_upd;

  logic                    press_edge, release_edge;
  logic [CfgDataWidth-1:0] period;
  logic [CmpWidth-1:0]     period_ext, period_eff, tick_ext, tmax_ext;
  logic                    expired;

  assign press_edge   = (prev_q == cfg_i.idle_level) && (pin_level_i != cfg_i.idle_level);
  assign release_edge = (prev_q != cfg_i.idle_level) && (pin_level_i == cfg_i.idle_level);

  // Shared expiry check; only one period is active per phase.
  assign period     = (phase_q == PH_DEBOUNCE) ? cfg_i.debounce_ticks : cfg_i.long_press_ticks;
  assign tick_inc   = (tick_q != TimerMax) ? tick_q + 1'b1 : tick_q;
  assign period_ext = CmpWidth'(period);
  assign tmax_ext   = CmpWidth'(TimerMax);
  assign tick_ext   = CmpWidth'(tick_inc);

  always_comb begin
    if (period_ext == '0) begin
      period_eff = CmpWidth'(1);
    end else if (period_ext > tmax_ext) begin
      period_eff = tmax_ext;
    end else begin
      period_eff = period_ext;
    end
  end

  assign expired = tick_ext >= period_eff;

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    event_upd = event_q;
    short_upd = short_q;
    long_upd  = long_q;
    case (phase_q)
      PH_IDLE: begin
        if (press_edge) begin
          phase_d = PH_DEBOUNCE;
          tick_d  = '0;
        end
      end
      PH_DEBOUNCE: begin
        tick_d = tick_inc;
        if (expired) begin
          tick_d  = '0;
          phase_d = (pin_level_i != cfg_i.idle_level) ? PH_PRESSED : PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (release_edge) begin
          short_upd = (short_q != CountMax) ? short_q + 1'b1 : short_q;
          event_upd = EV_SHORT;
          phase_d   = PH_IDLE;
          tick_d    = '0;
        end else begin
          tick_d = tick_inc;
          if (expired) begin
            long_upd  = (long_q != CountMax) ? long_q + 1'b1 : long_q;
            event_upd = EV_LONG;
            phase_d   = PH_HELD;
            tick_d    = '0;
          end
        end
      end
      default: begin
        if (release_edge) begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      end
    endcase

    // Read reports the updated values, then clears them.
    event_d = read_clear_i ? EV_NONE : event_upd;
    short_d = read_clear_i ? '0 : short_upd;
    long_d  = read_clear_i ? '0 : long_upd;

    result_o.press_event  = event_upd;
    result_o.short_count  = OutCntWidth'(short_upd);
    result_o.long_count   = OutCntWidth'(long_upd);
    result_o.button_state = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      event_q <= EV_NONE;
      tick_q  <= '0;
      prev_q  <= 1'b0;
      short_q <= '0;
      long_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      event_q <= event_d;
      tick_q  <= tick_d;
      prev_q  <= pin_level_i;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/button_press_classifier_top.sv =====
// Top level: button press classifier with config registers and result register.
// Each accepted input beat yields a registered result beat in the cycle after it is accepted.
// Throughput: one beat per cycle; the state update is a single compare-and-count.
// The result register frees as soon as its beat is taken, so input is stalled
// only while a result waits and the sink holds ready low.
// Reset: asynchronous, active low; config returns to 50/1000/0, state to idle.
`default_nettype none
module button_press_classifier_top #(
  parameter int unsigned COUNT_WIDTH = 8,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [bpc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire [bpc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  bpc_in_if.sink                           in_if,
  bpc_out_if.source                        out_if
);
  import bpc_pkg::*;

  bpc_cfg_t    cfg_q;
  bpc_result_t res_d, res_q;
  logic        out_valid_q;
  logic        accept;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= CfgDataWidth'(50);
      cfg_q.long_press_ticks <= CfgDataWidth'(1000);
      cfg_q.idle_level       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= cfg_data_i;
        CFG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data_i;
        CFG_IDLE_LEVEL:       cfg_q.idle_level       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bpc_fsm #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .pin_level_i (in_if.pin_level),
    .read_clear_i(in_if.read_and_clear),
    .cfg_i       (cfg_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.press_event  = res_q.press_event;
  assign out_if.short_count  = res_q.short_count;
  assign out_if.long_count   = res_q.long_count;
  assign out_if.button_state = res_q.button_state;

endmodule
`default_nettype wire
